FILE: design/sampm_pkg.sv
// shared constants, types and register map for the stepper angle move pulser
package sampm_pkg;

    localparam int STEPS_W      = 16;
    localparam int HALF_W       = 24;
    localparam int ANGLE_W      = 9;
    localparam int EDGES_W      = 17;
    localparam int PRODUCT_W    = STEPS_W + ANGLE_W;
    localparam int TIMER_BITS_DEFAULT = 24;

    // angle saturates at one full turn
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 9'd360;

    // p / 360 = (p >> 3) / 45, and x / 45 = (x * RECIP_45) >> RECIP_SHIFT for x < 2^22
    localparam int QUOT_IN_W    = PRODUCT_W - 3;
    localparam int RECIP_W      = 27;
    localparam int RECIP_SHIFT  = 32;
    localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;

    // item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_MOVE  = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_STEPS_PER_REV = 1'b0;
    localparam logic REG_HALF_PERIOD   = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // load strobes for the scaling pipeline stages
    typedef struct packed {
        logic load_product;
        logic load_target;
    } pipe_ctl_t;

endpackage

FILE: design/sampm_angle_scale.sv
// two-stage angle to step-count scaler: multiply, then divide by 360 via reciprocal
module sampm_angle_scale
(
    input  logic                             clk,
    input  sampm_pkg::pipe_ctl_t             ctl,
    input  logic [sampm_pkg::ANGLE_W-1:0]    angle,
    input  logic [sampm_pkg::STEPS_W-1:0]    steps_per_rev,
    output logic [sampm_pkg::STEPS_W-1:0]    target
);

    localparam int QUOT_FULL_W = sampm_pkg::QUOT_IN_W + sampm_pkg::RECIP_W;

    logic [sampm_pkg::ANGLE_W-1:0]   angle_sat;
    logic [sampm_pkg::PRODUCT_W-1:0] product_next;
    logic [sampm_pkg::PRODUCT_W-1:0] product_reg;
    logic [sampm_pkg::QUOT_IN_W-1:0] quot_in;
    logic [QUOT_FULL_W-1:0]          quot_full;
    logic [sampm_pkg::STEPS_W-1:0]   target_next;
    logic [sampm_pkg::STEPS_W-1:0]   target_reg;

    always_comb
    begin
        angle_sat    = (angle > sampm_pkg::ANGLE_MAX) ? sampm_pkg::ANGLE_MAX : angle;
        product_next = sampm_pkg::PRODUCT_W'(steps_per_rev)
                     * sampm_pkg::PRODUCT_W'(angle_sat);
    end

    // divide by 8 is a shift, the remaining divide by 45 a reciprocal multiply
    always_comb
    begin
        quot_in     = product_reg[sampm_pkg::PRODUCT_W-1:3];
        quot_full   = QUOT_FULL_W'(quot_in) * QUOT_FULL_W'(sampm_pkg::RECIP_45);
        target_next = quot_full[sampm_pkg::RECIP_SHIFT +: sampm_pkg::STEPS_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_product)
        begin
            product_reg <= product_next;
        end
        if (ctl.load_target)
        begin
            target_reg <= target_next;
        end
    end

    assign target = target_reg;

endmodule

FILE: design/stepper_angle_move_pulser.sv
// top level: step/direction pulse generator with angle moves and tick-driven edges
//
// one stepper motor step/direction generator. each input transaction is either a
// timer tick (func = 0) or a move-to-angle command (func = 1). a move converts the
// angle (saturated at 360) to target = steps_per_rev * angle / 360, truncated, sets
// the direction line, loads twice the step difference as edges to go and takes the
// target as the new position at once; a move that arrives while edges remain is
// dropped and flagged in rejected. ticks advance a saturating counter and produce
// one step-line edge each time it reaches half_period while edges remain; the first
// edge follows on the first tick after a move. every input transaction yields
// exactly one result transaction carrying step_level, direction, busy_res and
// rejected as they stand after that item. the block takes one transaction per clock
// unless in_stall holds it off; each item passes through an input register, the
// 16x9 product register, the reciprocal multiply that divides by 360, and the state
// update that writes the result register. stages move independently, so bubbles
// close up and new items are taken while a finished result is stalled.
// registers: steps_per_rev at byte address 0, half_period at byte address 4; write
// them only while no transaction is in flight.
module stepper_angle_move_pulser
#(
    parameter int TIMER_BITS = sampm_pkg::TIMER_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // apb-style configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sampm_pkg::PADDR_W-1:0]     paddr,
    input  logic [sampm_pkg::PDATA_W-1:0]     pwdata,
    output logic [sampm_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,

    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [sampm_pkg::ANGLE_W-1:0]     angle,

    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              step_level,
    output logic                              direction,
    output logic                              busy_res,
    output logic                              rejected
);

    localparam int CMP_W = (TIMER_BITS > sampm_pkg::HALF_W) ? TIMER_BITS : sampm_pkg::HALF_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // configuration registers
    logic [sampm_pkg::STEPS_W-1:0] steps_per_rev_reg;
    logic [sampm_pkg::HALF_W-1:0]  half_period_reg;
    logic                          cfg_write;

    // pipeline control
    logic                          take_out;
    logic                          free0;
    logic                          free1;
    logic                          free2;
    logic                          accept;
    logic                          adv0;
    logic                          adv1;
    logic                          adv2;
    logic                          v0_reg;
    logic                          v0_next;
    logic                          v1_reg;
    logic                          v1_next;
    logic                          v2_reg;
    logic                          v2_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    sampm_pkg::pipe_ctl_t          scale_ctl;

    // pipeline payload
    logic                          func0_reg;
    logic [sampm_pkg::ANGLE_W-1:0] angle0_reg;
    logic                          func1_reg;
    logic                          func2_reg;
    logic [sampm_pkg::STEPS_W-1:0] target;

    // motor state
    logic [sampm_pkg::STEPS_W-1:0] position_reg;
    logic [sampm_pkg::STEPS_W-1:0] position_next;
    logic [sampm_pkg::EDGES_W-1:0] edges_left_reg;
    logic [sampm_pkg::EDGES_W-1:0] edges_left_next;
    logic [TIMER_BITS-1:0]         elapsed_reg;
    logic [TIMER_BITS-1:0]         elapsed_next;
    logic                          line_level_reg;
    logic                          line_level_next;
    logic                          dir_level_reg;
    logic                          dir_level_next;
    logic                          rej_reg;
    logic                          rej_next;

    // datapath temporaries
    logic [TIMER_BITS-1:0]         elapsed_inc;
    logic [CMP_W-1:0]              threshold;
    logic [sampm_pkg::STEPS_W-1:0] step_diff;
    logic                          busy;

    //------------------------------------------------------------------
    // configuration port
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_per_rev_reg <= sampm_pkg::STEPS_W'(200);
            half_period_reg   <= sampm_pkg::HALF_W'(1000);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sampm_pkg::REG_STEPS_PER_REV:
                begin
                    steps_per_rev_reg <= pwdata[sampm_pkg::STEPS_W-1:0];
                end
                sampm_pkg::REG_HALF_PERIOD:
                begin
                    half_period_reg <= pwdata[sampm_pkg::HALF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sampm_pkg::REG_STEPS_PER_REV:
                prdata = sampm_pkg::PDATA_W'(steps_per_rev_reg);
            sampm_pkg::REG_HALF_PERIOD:
                prdata = sampm_pkg::PDATA_W'(half_period_reg);
            default:
                prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // pipeline flow: each stage moves when the next one is empty or moving
    //------------------------------------------------------------------
    always_comb
    begin
        take_out = ~out_valid_reg | ~out_stall;
        free2    = ~v2_reg | take_out;
        free1    = ~v1_reg | free2;
        free0    = ~v0_reg | free1;
        accept   = in_valid & free0;
        adv0     = v0_reg & free1;
        adv1     = v1_reg & free2;
        adv2     = v2_reg & take_out;

        v0_next        = accept | (v0_reg & ~free1);
        v1_next        = adv0 | (v1_reg & ~free2);
        v2_next        = adv1 | (v2_reg & ~take_out);
        out_valid_next = adv2 | (out_valid_reg & out_stall);

        scale_ctl.load_product = adv0;
        scale_ctl.load_target  = adv1;
    end

    assign in_stall = ~free0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v0_reg        <= v0_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func0_reg  <= func;
            angle0_reg <= angle;
        end
        if (adv0)
        begin
            func1_reg <= func0_reg;
        end
        if (adv1)
        begin
            func2_reg <= func1_reg;
        end
    end

    // angle to target steps, two stages
    sampm_angle_scale u_scale
    (
        .clk           (clk),
        .ctl           (scale_ctl),
        .angle         (angle0_reg),
        .steps_per_rev (steps_per_rev_reg),
        .target        (target)
    );

    //------------------------------------------------------------------
    // state update, applied as the item enters the result register
    //------------------------------------------------------------------
    assign busy = |edges_left_reg;

    always_comb
    begin
        // half_period is clipped to the counter maximum before the compare
        threshold = (CMP_W'(half_period_reg) > CMP_W'(TIMER_MAX))
                  ? CMP_W'(TIMER_MAX) : CMP_W'(half_period_reg);
        elapsed_inc = (elapsed_reg == TIMER_MAX) ? elapsed_reg
                                                 : elapsed_reg + TIMER_BITS'(1);
        step_diff = (target > position_reg) ? (target - position_reg)
                                            : (position_reg - target);

        position_next   = position_reg;
        edges_left_next = edges_left_reg;
        elapsed_next    = elapsed_reg;
        line_level_next = line_level_reg;
        dir_level_next  = dir_level_reg;
        rej_next        = 1'b0;

        if (func2_reg == sampm_pkg::FUNC_MOVE)
        begin
            if (busy)
            begin
                // move while edges remain is dropped
                rej_next = 1'b1;
            end
            else
            begin
                dir_level_next  = (target > position_reg);
                edges_left_next = {step_diff, 1'b0};
                position_next   = target;
                // counter at max so the next tick gives the first edge
                elapsed_next    = TIMER_MAX;
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (busy && (CMP_W'(elapsed_inc) >= threshold))
            begin
                elapsed_next    = '0;
                edges_left_next = edges_left_reg - sampm_pkg::EDGES_W'(1);
                line_level_next = ~edges_left_next[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            edges_left_reg <= '0;
            elapsed_reg    <= '0;
            line_level_reg <= 1'b0;
            dir_level_reg  <= 1'b0;
            rej_reg        <= 1'b0;
        end
        else if (adv2)
        begin
            position_reg   <= position_next;
            edges_left_reg <= edges_left_next;
            elapsed_reg    <= elapsed_next;
            line_level_reg <= line_level_next;
            dir_level_reg  <= dir_level_next;
            rej_reg        <= rej_next;
        end
    end

    // state only changes when a new result is loaded, so it doubles as the result register
    assign out_valid  = out_valid_reg;
    assign step_level = line_level_reg;
    assign direction  = dir_level_reg;
    assign busy_res   = busy;
    assign rejected   = rej_reg;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------

    // a rejected move leaves edges pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rej_reg) |-> busy)
    else $error("rejected move reported with no edges pending");

    // while busy, edges only hold or count down by one
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> ((edges_left_reg == $past(edges_left_reg))
              || (edges_left_reg == $past(edges_left_reg) - sampm_pkg::EDGES_W'(1))))
    else $error("edge count changed by more than one while busy");

    // every consumed edge restarts the tick counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (($past(edges_left_reg) != '0)
          && (edges_left_reg == $past(edges_left_reg) - sampm_pkg::EDGES_W'(1)))
        |-> (elapsed_reg == '0))
    else $error("edge produced without clearing the tick counter");

endmodule

FILE: tb/stepper_angle_move_pulser_test.sv
`timescale 1ns / 1ps
// testbench for the stepper angle move pulser: directed and random transactions against a motor model

module stepper_angle_move_pulser_test;

    localparam int TIMER_W = sampm_pkg::TIMER_BITS_DEFAULT;
    localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_W) - 1;
    localparam int DEG_PER_REV = 360;
    localparam int LIMIT_CYCLES = 200000;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int RANDOM_PHASES = 8;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 10;

    // one input transaction and one result transaction
    typedef struct packed {
        logic                         func;
        logic [sampm_pkg::ANGLE_W-1:0] angle;
    } pulse_cmd_t;

    typedef struct packed {
        logic step_level;
        logic direction;
        logic busy;
        logic rejected;
    } pulse_out_t;

    // registers plus motor state, as the block keeps them
    typedef struct {
        logic [sampm_pkg::STEPS_W-1:0] steps_per_rev;
        logic [sampm_pkg::HALF_W-1:0]  half_period;
        logic [sampm_pkg::STEPS_W-1:0] position;
        logic [sampm_pkg::EDGES_W-1:0] edges_left;
        longint unsigned               elapsed;
        logic                          line_level;
        logic                          dir_level;
    } motor_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [sampm_pkg::PADDR_W-1:0]   paddr = '0;
    logic [sampm_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [sampm_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            func = sampm_pkg::FUNC_TICK;
    logic [sampm_pkg::ANGLE_W-1:0]   angle = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            step_level;
    logic                            direction;
    logic                            busy_res;
    logic                            rejected;

    // commands waiting to be driven, results waiting to come back
    pulse_cmd_t pending_cmds[$];
    pulse_out_t pending_outs[$];
    pulse_cmd_t next_cmd;
    pulse_out_t want;

    // motor_st follows accepted transactions, plan_st follows what has been queued
    motor_t motor_st;
    motor_t plan_st;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int planned_count = 0;
    int errors = 0;
    int cycle_count = 0;

    // idling mixes per phase: none, sender only, receiver only, both
    int send_modes[4] = '{0, 66, 0, 21};
    int stall_modes[4] = '{0, 0, 66, 21};

    stepper_angle_move_pulser #(
        .TIMER_BITS (TIMER_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .angle      (angle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_level (step_level),
        .direction  (direction),
        .busy_res   (busy_res),
        .rejected   (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // motor state right after reset
    function automatic motor_t motor_at_reset();
        motor_t m;
        m.steps_per_rev = 16'd200;
        m.half_period   = 24'd1000;
        m.position      = '0;
        m.edges_left    = '0;
        m.elapsed       = 0;
        m.line_level    = 1'b0;
        m.dir_level     = 1'b0;
        return m;
    endfunction

    // applies one transaction to a motor state and returns the lines after it
    function automatic pulse_out_t advance_motor(inout motor_t m, input pulse_cmd_t c);
        pulse_out_t r;
        logic [sampm_pkg::ANGLE_W-1:0]   a;
        logic [sampm_pkg::PRODUCT_W-1:0] product;
        logic [sampm_pkg::STEPS_W-1:0]   target;
        longint unsigned                 thr;
        r.rejected = 1'b0;
        if (c.func == sampm_pkg::FUNC_MOVE)
        begin
            if (m.edges_left != '0)
                r.rejected = 1'b1;
            else
            begin
                // angle saturates at one full turn
                a = (c.angle > sampm_pkg::ANGLE_MAX) ? sampm_pkg::ANGLE_MAX : c.angle;
                product = sampm_pkg::PRODUCT_W'(m.steps_per_rev)
                        * sampm_pkg::PRODUCT_W'(a);
                target = sampm_pkg::STEPS_W'(product / DEG_PER_REV);
                if (target > m.position)
                begin
                    m.dir_level  = 1'b1;
                    m.edges_left = {target - m.position, 1'b0};
                end
                else
                begin
                    // a move to the same spot still clears the direction line
                    m.dir_level  = 1'b0;
                    m.edges_left = {m.position - target, 1'b0};
                end
                m.position = target;
                // first edge on the next tick
                m.elapsed = TIMER_MAX;
            end
        end
        else
        begin
            thr = (m.half_period > TIMER_MAX) ? TIMER_MAX : m.half_period;
            if (m.elapsed < TIMER_MAX)
                m.elapsed++;
            if (m.edges_left != '0 && m.elapsed >= thr)
            begin
                m.elapsed = 0;
                m.edges_left--;
                m.line_level = ~m.edges_left[0];
            end
        end
        r.step_level = m.line_level;
        r.direction  = m.dir_level;
        r.busy       = (m.edges_left != '0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("cycle %0d: %s mismatch, got %0d, wanted %0d", cycle_count, what, got, exp_val);
        errors++;
    endtask

    // driver: offers the next queued command when the channel is free, idling at random by send_idle_pct
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= sampm_pkg::FUNC_TICK;
            angle    <= '0;
        end
        else
        begin
            // accepted transaction: predict its result now, in acceptance order
            if (in_valid && !in_stall)
                pending_outs.push_back(advance_motor(motor_st, pulse_cmd_t'({func, angle})));
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    func     <= next_cmd.func;
                    angle    <= next_cmd.angle;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_outs.size() == 0)
                    report_mismatch("unexpected result transaction", 1, 0);
                else
                begin
                    want = pending_outs.pop_front();
                    if (step_level !== want.step_level)
                        report_mismatch("step_level", step_level, want.step_level);
                    if (direction !== want.direction)
                        report_mismatch("direction", direction, want.direction);
                    if (busy_res !== want.busy)
                        report_mismatch("busy_res", busy_res, want.busy);
                    if (rejected !== want.rejected)
                        report_mismatch("rejected", rejected, want.rejected);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // apb write with junk above the field, then read back
    task automatic config_reg(input logic idx, input int unsigned field);
        logic [sampm_pkg::PDATA_W-1:0] mask;
        logic [sampm_pkg::PDATA_W-1:0] stored;
        mask   = (idx == sampm_pkg::REG_STEPS_PER_REV) ? 32'h0000_FFFF : 32'h00FF_FFFF;
        stored = field & mask;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | stored;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        if (idx == sampm_pkg::REG_STEPS_PER_REV)
            motor_st.steps_per_rev = stored[sampm_pkg::STEPS_W-1:0];
        else
            motor_st.half_period = stored[sampm_pkg::HALF_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
            report_mismatch("register read-back", prdata, stored);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic start_phase(input int unsigned spr, input int unsigned hp, input int mode);
        config_reg(sampm_pkg::REG_STEPS_PER_REV, spr);
        config_reg(sampm_pkg::REG_HALF_PERIOD, hp);
        send_idle_pct  = send_modes[mode];
        recv_stall_pct = stall_modes[mode];
        plan_st = motor_st;
    endtask

    task automatic plan_cmd(input logic f, input logic [sampm_pkg::ANGLE_W-1:0] a);
        pulse_cmd_t c;
        c = '{f, a};
        void'(advance_motor(plan_st, c));
        pending_cmds.push_back(c);
        planned_count++;
    endtask

    // ticks with junk angles until the planned move has used all its edges
    task automatic plan_drain();
        while (plan_st.edges_left != '0)
            plan_cmd(sampm_pkg::FUNC_TICK, sampm_pkg::ANGLE_W'($urandom));
    endtask

    function automatic logic [sampm_pkg::ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 9) == 0)
            return sampm_pkg::ANGLE_W'($urandom_range(361, 511));
        return sampm_pkg::ANGLE_W'($urandom_range(0, 360));
    endfunction

    // mostly whole moves with random content, some loose noise
    task automatic plan_random(input int budget);
        int start;
        int r;
        start = planned_count;
        while (planned_count - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                plan_drain();
                plan_cmd(sampm_pkg::FUNC_MOVE, pick_angle());
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    // a second move soon after, often while edges remain
                    repeat ($urandom_range(0, 3))
                        plan_cmd(sampm_pkg::FUNC_TICK, sampm_pkg::ANGLE_W'($urandom));
                    plan_cmd(sampm_pkg::FUNC_MOVE, pick_angle());
                    plan_drain();
                end
                else if (r < 60)
                    plan_drain();
                else
                    repeat ($urandom_range(0, 8))
                        plan_cmd(sampm_pkg::FUNC_TICK, sampm_pkg::ANGLE_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    plan_cmd(($urandom_range(0, 99) < 30) ? sampm_pkg::FUNC_MOVE
                                                          : sampm_pkg::FUNC_TICK,
                             sampm_pkg::ANGLE_W'($urandom));
            end
        end
        plan_drain();
    endtask

    // waits until every command is taken and every result checked
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || pending_outs.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int spr;
        int hp;
        motor_st = motor_at_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // one step per degree: tick while idle, move to the current spot,
        // a short move with a rejected move in the middle, then a move back
        start_phase(360, 1, 0);
        plan_cmd(sampm_pkg::FUNC_TICK, 9'h1FF);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd0);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd3);
        plan_cmd(sampm_pkg::FUNC_TICK, 9'd0);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'h1FF);
        plan_drain();
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd1);
        plan_drain();
        wait_drained();

        // zero steps per rev sends every target to 0, zero half period acts like 1
        start_phase(0, 0, 0);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd200);
        plan_drain();
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'h1FF);
        plan_cmd(sampm_pkg::FUNC_TICK, 9'h155);
        wait_drained();

        // angles above a full turn saturate
        start_phase(2, 2, 0);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'h1FF);
        plan_drain();
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd360);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd359);
        plan_drain();
        wait_drained();

        // random phases, small sizes so every move finishes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 9))
                0: spr = 0;
                1: spr = 1;
                default: spr = $urandom_range(2, 30);
            endcase
            case ($urandom_range(0, 9))
                0: hp = 0;
                1: hp = 1;
                2:
                begin
                    hp = $urandom_range(5, 9);
                    if (spr > 8)
                        spr = $urandom_range(1, 8);
                end
                default: hp = $urandom_range(1, 3);
            endcase
            start_phase(spr, hp, p % 4);
            plan_random(ITEMS_PER_PHASE);
            wait_drained();
        end

        // largest registers last: the full-turn move cannot finish, so only its
        // first edge and the rejected move after it are seen
        start_phase(65535, 16777215, 3);
        plan_cmd(sampm_pkg::FUNC_MOVE, 9'd360);
        repeat (6) plan_cmd(sampm_pkg::FUNC_TICK, sampm_pkg::ANGLE_W'($urandom));
        plan_cmd(sampm_pkg::FUNC_MOVE, pick_angle());
        repeat (4) plan_cmd(sampm_pkg::FUNC_TICK, sampm_pkg::ANGLE_W'($urandom));
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
